// ===== sv/hge_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman gram encoder package
// Shared constants, op codes, sequencer types and the chunk request word.
// ----------------------------------------------------------------------------
package hge_pkg;

	// default table geometry
	localparam int TABLE_ENTRIES_DEF = 256;
	localparam int MAX_CODE_BITS_DEF = 16;

	// fixed field widths
	localparam int KEY_W    = 64;
	localparam int WORD_W   = 32;
	localparam int CODE_W   = 16;
	localparam int LEN_W    = 5;
	localparam int CHUNK_W  = 33;
	localparam int CLEN_W   = 6;

	// chunk length of a literal: escape bit plus one word
	localparam logic [CLEN_W-1:0] LITERAL_LEN = 6'd33;

	// op codes
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_ENCODE = 2'd1;
	localparam logic [1:0] OP_SETOFF = 2'd2;

	// sequencer states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN
	} hge_state_t;

	// which lookup of a gram is running
	typedef enum logic [1:0] {
		PASS_FULL,
		PASS_LOW,
		PASS_HIGH
	} hge_pass_t;

	// chunk request from the sequencer to the emitter
	typedef struct packed {
		logic                valid;
		logic                hit;
		logic                last;
		logic [CODE_W-1:0]   code;
		logic [LEN_W-1:0]    len;
		logic [WORD_W-1:0]   word;
	} hge_emit_req_t;

endpackage

// ===== sv/hge_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gram code table
// Key and code memories, one write and one registered read port each.
// ----------------------------------------------------------------------------
module hge_table #(
	parameter int TABLE_ENTRIES = hge_pkg::TABLE_ENTRIES_DEF,
	parameter int MAX_CODE_BITS = hge_pkg::MAX_CODE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          key_we,
	input  logic                          code_we,
	input  logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
	input  logic [hge_pkg::KEY_W-1:0]     wr_key,
	input  logic [MAX_CODE_BITS-1:0]      wr_code,
	input  logic [hge_pkg::LEN_W-1:0]     wr_len,
	input  logic                          rd_en,
	input  logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
	output logic [hge_pkg::KEY_W-1:0]     rd_key,
	output logic [MAX_CODE_BITS-1:0]      rd_code,
	output logic [hge_pkg::LEN_W-1:0]     rd_len
);

	localparam int ENT_W = MAX_CODE_BITS + hge_pkg::LEN_W;

	logic [hge_pkg::KEY_W-1:0] key_mem [TABLE_ENTRIES];
	logic [ENT_W-1:0]          code_mem [TABLE_ENTRIES];
	logic [ENT_W-1:0]          ent_q;

	// write port
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[wr_addr] <= wr_key;
		end
		if (code_we) begin
			code_mem[wr_addr] <= {wr_len, wr_code};
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key <= key_mem[rd_addr];
			ent_q  <= code_mem[rd_addr];
		end
	end

	assign rd_code = ent_q[MAX_CODE_BITS-1:0];
	assign rd_len  = ent_q[ENT_W-1:MAX_CODE_BITS];

endmodule

// ===== sv/hge_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gram encoder sequencer
// Clearing sweep after reset, then linear table scans with one shared
// key comparator; decides hit, bigram split or literal for each gram.
// ----------------------------------------------------------------------------
module hge_seq #(
	parameter int TABLE_ENTRIES = hge_pkg::TABLE_ENTRIES_DEF,
	parameter int MAX_CODE_BITS = hge_pkg::MAX_CODE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             enc_start,
	input  logic [hge_pkg::KEY_W-1:0]        gram,
	input  logic [hge_pkg::KEY_W-1:0]        rd_key,
	input  logic [MAX_CODE_BITS-1:0]         rd_code,
	input  logic [hge_pkg::LEN_W-1:0]        rd_len,
	output logic                             busy,
	output logic                             clr_en,
	output logic                             rd_en,
	output logic [$clog2(TABLE_ENTRIES)-1:0] mem_addr,
	output hge_pkg::hge_emit_req_t           emit_req
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = IDX_W + 1;
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);

	hge_pkg::hge_state_t       state_q, state_d;
	hge_pkg::hge_pass_t        pass_q, pass_d;
	logic [CNT_W-1:0]          addr_q, addr_d;
	logic                      rd_vld_q, rd_vld_d;
	logic                      rd_last_q, rd_last_d;
	logic [hge_pkg::KEY_W-1:0] key_q, key_d;
	logic [hge_pkg::KEY_W-1:0] gram_q, gram_d;
	logic                      hit;
	logic                      miss;

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= hge_pkg::ST_CLEAR;
			pass_q    <= hge_pkg::PASS_FULL;
			addr_q    <= '0;
			rd_vld_q  <= 1'b0;
			rd_last_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			pass_q    <= pass_d;
			addr_q    <= addr_d;
			rd_vld_q  <= rd_vld_d;
			rd_last_q <= rd_last_d;
		end
	end

	// search key and gram
	always_ff @(posedge clk) begin
		key_q  <= key_d;
		gram_q <= gram_d;
	end

	// shared comparator on the registered read word
	assign hit  = rd_vld_q && (rd_len != '0) && (rd_key == key_q);
	assign miss = rd_vld_q && rd_last_q && !hit;

	assign busy     = (state_q != hge_pkg::ST_IDLE);
	assign mem_addr = addr_q[IDX_W-1:0];

	// next state and outputs
	always_comb begin
		state_d   = state_q;
		pass_d    = pass_q;
		addr_d    = addr_q;
		rd_vld_d  = 1'b0;
		rd_last_d = 1'b0;
		key_d     = key_q;
		gram_d    = gram_q;
		clr_en    = 1'b0;
		rd_en     = 1'b0;
		emit_req  = '0;
		unique case (state_q)
			hge_pkg::ST_CLEAR: begin
				clr_en = 1'b1;
				if (addr_q == CNT_LAST) begin
					addr_d  = '0;
					state_d = hge_pkg::ST_IDLE;
				end else begin
					addr_d = addr_q + 1'b1;
				end
			end
			hge_pkg::ST_IDLE: begin
				if (enc_start) begin
					key_d   = gram;
					gram_d  = gram;
					pass_d  = hge_pkg::PASS_FULL;
					addr_d  = '0;
					state_d = hge_pkg::ST_SCAN;
				end
			end
			hge_pkg::ST_SCAN: begin
				if (hit || miss) begin
					addr_d        = '0;
					emit_req.hit  = hit;
					emit_req.code = hge_pkg::CODE_W'(rd_code);
					emit_req.len  = rd_len;
					unique case (pass_q)
						hge_pkg::PASS_FULL: begin
							if (hit || (gram_q[39:32] == '0)) begin
								emit_req.valid = 1'b1;
								emit_req.last  = 1'b1;
								emit_req.word  = gram_q[31:0];
								state_d        = hge_pkg::ST_IDLE;
							end else begin
								// missed bigram: look up each word on its own
								key_d  = {32'b0, gram_q[31:0]};
								pass_d = hge_pkg::PASS_LOW;
							end
						end
						hge_pkg::PASS_LOW: begin
							emit_req.valid = 1'b1;
							emit_req.word  = gram_q[31:0];
							key_d          = {32'b0, gram_q[63:32]};
							pass_d         = hge_pkg::PASS_HIGH;
						end
						hge_pkg::PASS_HIGH: begin
							emit_req.valid = 1'b1;
							emit_req.last  = 1'b1;
							emit_req.word  = gram_q[63:32];
							state_d        = hge_pkg::ST_IDLE;
						end
						default: begin
							state_d = hge_pkg::ST_IDLE;
						end
					endcase
				end else if (addr_q < CNT_END) begin
					// issue the next read of the scan
					rd_en     = 1'b1;
					rd_vld_d  = 1'b1;
					rd_last_d = (addr_q == CNT_LAST);
					addr_d    = addr_q + 1'b1;
				end
			end
			default: begin
				state_d = hge_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/hge_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk emitter
// Holds the bit offset, forms each chunk, checks overflow and registers
// the result word.
// ----------------------------------------------------------------------------
module hge_emit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hge_pkg::hge_emit_req_t        req,
	input  logic                          set_en,
	input  logic [hge_pkg::WORD_W-1:0]    set_offset,
	output logic                          valid,
	output logic [hge_pkg::CHUNK_W-1:0]   chunk_bits,
	output logic [hge_pkg::CLEN_W-1:0]    chunk_length,
	output logic [hge_pkg::WORD_W-1:0]    chunk_offset,
	output logic                          overflow,
	output logic                          last
);

	logic [hge_pkg::WORD_W-1:0]  off_q;
	logic                        valid_q;
	logic [hge_pkg::CHUNK_W-1:0] bits;
	logic [hge_pkg::CLEN_W-1:0]  len;
	logic [hge_pkg::WORD_W:0]    end_pos;
	logic                        ovf;

	// chunk format: hit is a 1 bit then the code, literal a 0 bit then the word
	always_comb begin
		if (req.hit) begin
			bits = {16'b0, req.code, 1'b1};
			len  = hge_pkg::CLEN_W'(req.len) + 1'b1;
		end else begin
			bits = {req.word, 1'b0};
			len  = hge_pkg::LITERAL_LEN;
		end
		end_pos = {1'b0, off_q} + (hge_pkg::WORD_W + 1)'(len);
		ovf     = end_pos[hge_pkg::WORD_W];
	end

	// offset register; held on overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= req.valid;
			if (set_en) begin
				off_q <= set_offset;
			end else if (req.valid && !ovf) begin
				off_q <= end_pos[hge_pkg::WORD_W-1:0];
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (req.valid) begin
			chunk_bits   <= bits;
			chunk_length <= len;
			chunk_offset <= off_q;
			overflow     <= ovf;
			last         <= req.last;
		end
	end

	assign valid = valid_q;

endmodule

// ===== sv/huffman_gram_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman gram encoder with literal escape
// Table lookup encoder emitting bit chunks tagged with a running bit offset.
// ----------------------------------------------------------------------------
// Usage:
//   A command word is taken on a rising edge with start high and busy low.
//   op 0 loads a table slot and op 2 sets the bit offset; both complete in
//   the cycle they are taken, give no result and leave busy low.
//   op 1 encodes a gram: busy rises and the table is scanned one slot a
//   cycle through the single read port and key comparator. A lookup ends
//   at the first live slot holding the key, or as a miss after the last
//   slot. A missed bigram runs two further lookups, low word then high.
//   Each result word is shown on chunk_* for one cycle with valid high, the
//   cycle after its lookup ends; last marks the final word of a gram.
//   The receiver cannot stall; the next command may be taken in the cycle
//   the final word is shown.
//   Reset: the offset is zeroed and a clearing sweep empties the table,
//   with busy high meanwhile.
// ----------------------------------------------------------------------------
module huffman_gram_encoder #(
	parameter int TABLE_ENTRIES = hge_pkg::TABLE_ENTRIES_DEF,
	parameter int MAX_CODE_BITS = hge_pkg::MAX_CODE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  op,
	input  logic [hge_pkg::KEY_W-1:0]   gram,
	input  logic [7:0]                  entry_index,
	input  logic [hge_pkg::KEY_W-1:0]   entry_key,
	input  logic [hge_pkg::CODE_W-1:0]  entry_code,
	input  logic [hge_pkg::LEN_W-1:0]   entry_length,
	input  logic [hge_pkg::WORD_W-1:0]  start_offset,
	output logic                        valid,
	output logic [hge_pkg::CHUNK_W-1:0] chunk_bits,
	output logic [hge_pkg::CLEN_W-1:0]  chunk_length,
	output logic [hge_pkg::WORD_W-1:0]  chunk_offset,
	output logic                        overflow,
	output logic                        last
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	logic                          accept;
	logic                          ld_en;
	logic                          enc_start;
	logic                          set_en;
	logic [16:0]                   idx_ext;
	logic [IDX_W-1:0]              ld_addr;
	logic [hge_pkg::LEN_W-1:0]     ld_len;
	logic [16:0]                   ld_mask;
	logic [hge_pkg::CODE_W-1:0]    ld_code;
	logic                          clr_en;
	logic                          rd_en;
	logic [IDX_W-1:0]              mem_addr;
	logic [IDX_W-1:0]              wr_addr;
	logic [MAX_CODE_BITS-1:0]      wr_code;
	logic [hge_pkg::LEN_W-1:0]     wr_len;
	logic [hge_pkg::KEY_W-1:0]     rd_key;
	logic [MAX_CODE_BITS-1:0]      rd_code;
	logic [hge_pkg::LEN_W-1:0]     rd_len;
	hge_pkg::hge_emit_req_t        emit_req;

	// command decode
	assign accept    = start && !busy;
	assign enc_start = accept && (op == hge_pkg::OP_ENCODE);
	assign set_en    = accept && (op == hge_pkg::OP_SETOFF);
	assign ld_en     = accept && (op == hge_pkg::OP_LOAD) &&
	                   (32'(entry_index) < 32'(TABLE_ENTRIES));

	// load word: saturate the length, mask the code to it
	always_comb begin
		idx_ext = 17'(entry_index);
		ld_addr = idx_ext[IDX_W-1:0];
		if (entry_length > hge_pkg::LEN_W'(MAX_CODE_BITS)) begin
			ld_len = hge_pkg::LEN_W'(MAX_CODE_BITS);
		end else begin
			ld_len = entry_length;
		end
		ld_mask = (17'd1 << ld_len) - 17'd1;
		ld_code = entry_code & ld_mask[15:0];
	end

	// write port shared by the clearing sweep and loads
	always_comb begin
		if (clr_en) begin
			wr_addr = mem_addr;
			wr_code = '0;
			wr_len  = '0;
		end else begin
			wr_addr = ld_addr;
			wr_code = ld_code[MAX_CODE_BITS-1:0];
			wr_len  = ld_len;
		end
	end

	hge_table #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) u_table (
		.clk     (clk),
		.key_we  (ld_en),
		.code_we (ld_en || clr_en),
		.wr_addr (wr_addr),
		.wr_key  (entry_key),
		.wr_code (wr_code),
		.wr_len  (wr_len),
		.rd_en   (rd_en),
		.rd_addr (mem_addr),
		.rd_key  (rd_key),
		.rd_code (rd_code),
		.rd_len  (rd_len)
	);

	hge_seq #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.enc_start (enc_start),
		.gram      (gram),
		.rd_key    (rd_key),
		.rd_code   (rd_code),
		.rd_len    (rd_len),
		.busy      (busy),
		.clr_en    (clr_en),
		.rd_en     (rd_en),
		.mem_addr  (mem_addr),
		.emit_req  (emit_req)
	);

	hge_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (emit_req),
		.set_en       (set_en),
		.set_offset   (start_offset),
		.valid        (valid),
		.chunk_bits   (chunk_bits),
		.chunk_length (chunk_length),
		.chunk_offset (chunk_offset),
		.overflow     (overflow),
		.last         (last)
	);

endmodule

// ===== bench/hge_chunk_board_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk scoreboard for the Huffman gram encoder bench
// Shadows the code table and the running bit offset, works out the chunks
// each accepted word must produce and checks the chunks the encoder shows.
// ----------------------------------------------------------------------------
package hge_chunk_board_pkg;

	import hge_pkg::*;

	// one expected output chunk
	typedef struct {
		logic [CHUNK_W-1:0] bits;
		logic [CLEN_W-1:0]  length;
		logic [WORD_W-1:0]  offset;
		logic               ovf;
		logic               fin;
	} chunk_t;

	class chunk_board;
		logic [KEY_W-1:0]  slot_key  [TABLE_ENTRIES_DEF];
		logic [CODE_W-1:0] slot_code [TABLE_ENTRIES_DEF];
		logic [LEN_W-1:0]  slot_len  [TABLE_ENTRIES_DEF];
		logic [WORD_W-1:0] bit_pos;
		chunk_t            due_chunks [$];
		int                errors;

		function new();
			for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
				slot_key[i]  = '0;
				slot_code[i] = '0;
				slot_len[i]  = '0;
			end
			bit_pos = '0;
			errors  = 0;
		endfunction

		// lowest live slot holding the key wins
		function bit find_slot(input logic [KEY_W-1:0] key, output logic [CODE_W-1:0] c,
				output logic [LEN_W-1:0] l);
			c = '0;
			l = '0;
			for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
				if (slot_len[i] != 0 && slot_key[i] == key) begin
					c = slot_code[i];
					l = slot_len[i];
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		// queue one chunk at the current offset; advance unless it overflows
		function void push_chunk(input logic [CHUNK_W-1:0] bits, input logic [CLEN_W-1:0] len,
				input logic fin);
			logic [WORD_W:0] stop;
			chunk_t c;
			stop     = {1'b0, bit_pos} + (WORD_W+1)'(len);
			c.bits   = bits;
			c.length = len;
			c.offset = bit_pos;
			c.ovf    = stop[WORD_W];
			c.fin    = fin;
			due_chunks.push_back(c);
			if (!stop[WORD_W])
				bit_pos = stop[WORD_W-1:0];
		endfunction

		// hit: prefix 1 plus code; miss: prefix 0 plus the 32-bit word
		function void push_word(input logic [KEY_W-1:0] key, input logic fin);
			logic [CODE_W-1:0] c;
			logic [LEN_W-1:0]  l;
			if (find_slot(key, c, l))
				push_chunk({16'b0, c, 1'b1}, CLEN_W'(l) + 6'd1, fin);
			else
				push_chunk({key[WORD_W-1:0], 1'b0}, LITERAL_LEN, fin);
		endfunction

		// an accepted command word
		function void note_command(input logic [1:0] op, input logic [KEY_W-1:0] gram,
				input logic [7:0] idx, input logic [KEY_W-1:0] key,
				input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
				input logic [WORD_W-1:0] offs);
			logic [LEN_W-1:0]  l;
			logic [CODE_W:0]   mask;
			logic [CODE_W-1:0] c;
			case (op)
				OP_LOAD: begin
					// over-long lengths saturate, code trimmed to the length
					l = (len > MAX_CODE_BITS_DEF) ? LEN_W'(MAX_CODE_BITS_DEF) : len;
					mask = (17'd1 << l) - 17'd1;
					slot_key[idx]  = key;
					slot_len[idx]  = l;
					slot_code[idx] = (l == 0) ? '0 : (code & mask[CODE_W-1:0]);
				end
				OP_SETOFF: begin
					bit_pos = offs;
				end
				OP_ENCODE: begin
					if (find_slot(gram, c, l))
						push_chunk({16'b0, c, 1'b1}, CLEN_W'(l) + 6'd1, 1'b1);
					else if (gram[39:32] != 8'h00) begin
						// missed bigram: low word, then high word
						push_word({32'b0, gram[31:0]}, 1'b0);
						push_word({32'b0, gram[63:32]}, 1'b1);
					end else
						push_chunk({gram[31:0], 1'b0}, LITERAL_LEN, 1'b1);
				end
				default: begin
					// spare op code: no effect
				end
			endcase
		endfunction

		// compare a shown chunk against the oldest expectation
		function void check_chunk(input logic [CHUNK_W-1:0] bits, input logic [CLEN_W-1:0] length,
				input logic [WORD_W-1:0] offset, input logic ovf, input logic fin);
			chunk_t w;
			if (due_chunks.size() == 0) begin
				$error("unexpected chunk: bits %h length %0d offset %h", bits, length, offset);
				errors++;
				return;
			end
			w = due_chunks.pop_front();
			if (bits !== w.bits) begin
				$error("chunk_bits: expected %h, got %h", w.bits, bits);
				errors++;
			end
			if (length !== w.length) begin
				$error("chunk_length: expected %0d, got %0d", w.length, length);
				errors++;
			end
			if (offset !== w.offset) begin
				$error("chunk_offset: expected %h, got %h", w.offset, offset);
				errors++;
			end
			if (ovf !== w.ovf) begin
				$error("overflow: expected %b, got %b", w.ovf, ovf);
				errors++;
			end
			if (fin !== w.fin) begin
				$error("last: expected %b, got %b", w.fin, fin);
				errors++;
			end
		endfunction

		// anything still owed at the end is a miss
		function void drain();
			chunk_t w;
			while (due_chunks.size() != 0) begin
				w = due_chunks.pop_front();
				$error("missing chunk: bits %h length %0d offset %h", w.bits, w.length, w.offset);
				errors++;
			end
		endfunction
	endclass

endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman gram encoder bench
// Drives load, encode and offset words through the start/busy handshake:
// a directed run over table edges, bigrams, literals and offset overflow,
// then random words built around the loaded keys. Every chunk shown is
// checked against the scoreboard's shadow of the table and offset.
// ----------------------------------------------------------------------------
module tb_top;

	import hge_pkg::*;
	import hge_chunk_board_pkg::*;

	localparam logic [1:0] OP_SPARE   = 2'd3;
	localparam int         RAND_WORDS = 750;
	localparam int         TAIL       = 2 * (TABLE_ENTRIES_DEF + 1) + 16;
	localparam int unsigned CYCLE_CAP = 4_000_000;
	localparam int         POOL_MAX   = 48;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [1:0]          op;
	logic [KEY_W-1:0]    gram;
	logic [7:0]          entry_index;
	logic [KEY_W-1:0]    entry_key;
	logic [CODE_W-1:0]   entry_code;
	logic [LEN_W-1:0]    entry_length;
	logic [WORD_W-1:0]   start_offset;
	logic                valid;
	logic [CHUNK_W-1:0]  chunk_bits;
	logic [CLEN_W-1:0]   chunk_length;
	logic [WORD_W-1:0]   chunk_offset;
	logic                overflow;
	logic                last;

	chunk_board          board;
	bit                  idle_ok;
	int unsigned         cycles = 0;
	logic [KEY_W-1:0]    full_keys [$];
	logic [KEY_W-1:0]    word_keys [$];

	huffman_gram_encoder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.gram         (gram),
		.entry_index  (entry_index),
		.entry_key    (entry_key),
		.entry_code   (entry_code),
		.entry_length (entry_length),
		.start_offset (start_offset),
		.valid        (valid),
		.chunk_bits   (chunk_bits),
		.chunk_length (chunk_length),
		.chunk_offset (chunk_offset),
		.overflow     (overflow),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_CAP) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// chunk checker: results cannot be held off, take every strobe
	always @(posedge clk) begin
		if (arst_n && valid)
			board.check_chunk(chunk_bits, chunk_length, chunk_offset, overflow, last);
	end

	// present one command word and hold it until taken
	task automatic send_cmd(input logic [1:0] c_op, input logic [KEY_W-1:0] c_gram,
			input logic [7:0] c_idx, input logic [KEY_W-1:0] c_key,
			input logic [CODE_W-1:0] c_code, input logic [LEN_W-1:0] c_len,
			input logic [WORD_W-1:0] c_offs);
		if (idle_ok && $urandom_range(0, 99) < 8) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		start        <= 1'b1;
		op           <= c_op;
		gram         <= c_gram;
		entry_index  <= c_idx;
		entry_key    <= c_key;
		entry_code   <= c_code;
		entry_length <= c_len;
		start_offset <= c_offs;
		do @(posedge clk); while (busy);
		board.note_command(c_op, c_gram, c_idx, c_key, c_code, c_len, c_offs);
	endtask

	// directed helpers: unused fields carry random filler
	task automatic load_slot(input logic [7:0] idx, input logic [KEY_W-1:0] key,
			input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
		send_cmd(OP_LOAD, {$urandom, $urandom}, idx, key, code, len, $urandom);
	endtask

	task automatic encode(input logic [KEY_W-1:0] g);
		send_cmd(OP_ENCODE, g, 8'($urandom), {$urandom, $urandom}, 16'($urandom),
			5'($urandom), $urandom);
	endtask

	task automatic set_offset(input logic [WORD_W-1:0] o);
		send_cmd(OP_SETOFF, {$urandom, $urandom}, 8'($urandom), {$urandom, $urandom},
			16'($urandom), 5'($urandom), o);
	endtask

	// key pools: bounded so that keys repeat and duplicates appear
	function automatic void keep_key(input logic [KEY_W-1:0] k, input bit is_word);
		if (is_word) begin
			word_keys.push_back(k);
			if (word_keys.size() > POOL_MAX)
				word_keys.delete($urandom_range(0, word_keys.size() - 1));
		end else begin
			full_keys.push_back(k);
			if (full_keys.size() > POOL_MAX)
				full_keys.delete($urandom_range(0, full_keys.size() - 1));
		end
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		logic [KEY_W-1:0] k;
		if (word_keys.size() != 0 && $urandom_range(0, 3) != 0) begin
			k = word_keys[$urandom_range(0, word_keys.size() - 1)];
			return k[WORD_W-1:0];
		end
		return $urandom;
	endfunction

	// key of some live slot, scanning from a random point
	function automatic logic [KEY_W-1:0] live_key(input logic [KEY_W-1:0] fallback);
		int base;
		int j;
		base = $urandom_range(0, TABLE_ENTRIES_DEF - 1);
		for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
			j = (base + i) % TABLE_ENTRIES_DEF;
			if (board.slot_len[j] != 0)
				return board.slot_key[j];
		end
		return fallback;
	endfunction

	// one random command word, biased towards table hits and bigrams
	task automatic rand_word();
		logic [KEY_W-1:0]  g;
		logic [KEY_W-1:0]  k;
		logic [WORD_W-1:0] hi;
		logic [WORD_W-1:0] lo;
		logic [WORD_W-1:0] o;
		logic [7:0]        ix;
		logic [CODE_W-1:0] cd;
		logic [LEN_W-1:0]  ln;
		logic [1:0]        c_op;
		int                pick;
		int                s;
		g    = {$urandom, $urandom};
		k    = {$urandom, $urandom};
		ix   = 8'($urandom);
		cd   = 16'($urandom);
		ln   = 5'($urandom_range(0, 31));
		o    = $urandom;
		c_op = OP_ENCODE;
		pick = $urandom_range(0, 99);
		if (pick < 22) begin
			c_op = OP_LOAD;
			s = $urandom_range(0, 99);
			if (s < 40 && full_keys.size() != 0)
				k = full_keys[$urandom_range(0, full_keys.size() - 1)];
			else if (s < 60 && word_keys.size() != 0)
				k = word_keys[$urandom_range(0, word_keys.size() - 1)];
			else if (s < 80) begin
				k = {32'b0, $urandom};
				keep_key(k, 1'b1);
			end else
				keep_key(k, 1'b0);
			s = $urandom_range(0, 99);
			if (s < 80)
				ln = 5'($urandom_range(1, MAX_CODE_BITS_DEF));
			else if (s < 90)
				ln = '0;
			else
				ln = 5'($urandom_range(MAX_CODE_BITS_DEF + 1, 31));
		end else if (pick < 82) begin
			s = $urandom_range(0, 99);
			if (s < 40)
				g = live_key(g);
			else if (s < 65) begin
				lo = pick_word();
				hi = pick_word();
				if (hi[7:0] == 8'h00)
					hi[7:0] = 8'($urandom_range(1, 255));
				g = {hi, lo};
			end else if (s < 80)
				g[39:32] = 8'h00;
			else if (s < 90 && full_keys.size() != 0)
				g = full_keys[$urandom_range(0, full_keys.size() - 1)];
		end else if (pick < 90) begin
			c_op = OP_SETOFF;
			s = $urandom_range(0, 99);
			if (s < 50)
				o = 32'hFFFF_FFFF - 32'($urandom_range(0, 80));
			else if (s < 75)
				o = 32'($urandom_range(0, 1000));
		end else
			c_op = OP_SPARE;
		send_cmd(c_op, g, ix, k, cd, ln, o);
	endtask

	// stimulus and final verdict
	initial begin
		logic [KEY_W-1:0] k1;
		board        = new();
		idle_ok      = 1'b1;
		arst_n       = 1'b0;
		start        = 1'b0;
		op           = OP_LOAD;
		gram         = '0;
		entry_index  = '0;
		entry_key    = '0;
		entry_code   = '0;
		entry_length = '0;
		start_offset = '0;
		k1           = 64'h8123_4567_89AB_CDEF;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// empty table: plain literal, then a bigram of two literals
		encode(64'h0);
		encode('1);
		// table edges, duplicate key, saturated length, trimmed code
		load_slot(8'd0, k1, 16'hFFFF, 5'd16);
		load_slot(8'd255, '1, 16'h0000, 5'd1);
		load_slot(8'd5, k1, 16'h0005, 5'd3);
		load_slot(8'd7, 64'h0000_0000_1234_5678, 16'hFFFF, 5'd31);
		load_slot(8'd8, 64'h0000_0000_0000_00AB, 16'h00F3, 5'd2);
		encode(k1);
		encode('1);
		// bigram with both words hit, then with both missed
		encode(64'h0000_00AB_1234_5678);
		encode(64'h0000_0001_FFFF_FFFF);
		// bigram byte clear: literal of the low word
		encode(64'hFFFF_FF00_1234_5678);
		// overflow holds the offset, second chunk judged at the same place
		set_offset(32'hFFFF_FFF0);
		encode(k1);
		encode(64'h0000_0001_FFFF_FFFF);
		// chunk that leaves the offset at its top value, then one that overflows
		set_offset(32'hFFFF_FFFD);
		encode('1);
		encode('1);
		// clearing the first duplicate exposes the next one
		load_slot(8'd0, k1, 16'h0000, 5'd0);
		encode(k1);
		send_cmd(OP_SPARE, {$urandom, $urandom}, 8'($urandom), {$urandom, $urandom},
			16'($urandom), 5'($urandom), $urandom);
		set_offset(32'h0);

		// random words, with one long stretch kept back to back
		for (int n = 0; n < RAND_WORDS; n++) begin
			idle_ok = !(n >= 300 && n < 450);
			rand_word();
		end
		start <= 1'b0;

		for (int n = 0; n < 4 * TAIL && board.due_chunks.size() != 0; n++)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);
		board.drain();
		if (board.errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/hge_pkg.sv
sv/hge_table.sv
sv/hge_seq.sv
sv/hge_emit.sv
sv/huffman_gram_encoder.sv
bench/hge_chunk_board_pkg.sv
bench/tb_top.sv
